>>> hdl/ldss_pkg.sv
package ldss_pkg;

	localparam int DEFICIT_BITS = 24;
	localparam int SHARE_BITS = 16;
	localparam int SHARE_REGS = 4;
	localparam int CLASS_COUNT_BITS = 3;
	localparam int WORD_LENGTH_BITS = 32;
	localparam int CHOSEN_BITS = 2;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 32;

	typedef logic signed [DEFICIT_BITS-1:0] deficit_t;
	typedef logic [SHARE_BITS-1:0] share_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_CLASS_COUNT = 3'd0,
		REG_WORD_LENGTH = 3'd1,
		REG_SHARE_FIRST = 3'd2
	} cfg_reg_t;

	localparam logic [CLASS_COUNT_BITS-1:0] CLASS_COUNT_RESET = 3'd2;
	localparam logic [WORD_LENGTH_BITS-1:0] WORD_LENGTH_RESET = 32'd1;
	localparam share_t SHARE_RESET [SHARE_REGS] = '{16'd32768, 16'd32768, 16'd0, 16'd0};

endpackage

>>> hdl/ldss_argmax.sv
module ldss_argmax
	import ldss_pkg::*;
#(
	parameter int N = 4,
	parameter int IDX_W = 2
) (
	input  deficit_t [N-1:0]   vals,
	input  logic [N-1:0]       active,
	output logic [IDX_W-1:0]   best
);

	localparam int LEAVES = 1 << IDX_W;
	localparam int NODES = 2 * LEAVES - 1;

	deficit_t          node_val [NODES];
	logic [IDX_W-1:0]  node_idx [NODES];
	logic              node_ok  [NODES];

	// Leaves sit in class order, so a tie at any node keeps the left (lower) index.
	for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
		if (i < N) begin : g_real
			assign node_val[LEAVES-1+i] = vals[i];
			assign node_ok[LEAVES-1+i] = active[i];
		end else begin : g_pad
			assign node_val[LEAVES-1+i] = '0;
			assign node_ok[LEAVES-1+i] = 1'b0;
		end
		assign node_idx[LEAVES-1+i] = IDX_W'(i);
	end

	for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
		logic take_right;
		assign take_right = node_ok[2*n+2] &&
			(!node_ok[2*n+1] || ($signed(node_val[2*n+2]) > $signed(node_val[2*n+1])));
		assign node_val[n] = take_right ? node_val[2*n+2] : node_val[2*n+1];
		assign node_idx[n] = take_right ? node_idx[2*n+2] : node_idx[2*n+1];
		assign node_ok[n] = node_ok[2*n+1] || node_ok[2*n+2];
	end

	assign best = node_idx[0];

endmodule

>>> hdl/largest_deficit_symbol_scheduler.sv
// Weighted fair-share scheduler. Every accepted tick transaction adds each active class's
// share (unsigned, SHARE_FRAC_BITS fraction bits) to its saturating 24-bit deficit, picks
// the class with the largest deficit (lowest index on ties), takes one unit from it and
// returns the pick with a flag on the last tick of the word; deficits and position then
// clear, and restart clears them before its own tick. One tick is taken every cycle unless a
// pick waits untaken: the add, the comparison tree and the subtract all sit between the deficit
// registers and the result register, which frees itself when taken in the same cycle.
// Write configuration only while no tick is in flight.
module largest_deficit_symbol_scheduler
	import ldss_pkg::*;
#(
	parameter int MAX_CLASSES = 4,
	parameter int SHARE_FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                         tick_valid,
	output logic                         tick_ready,
	input  logic                         restart,
	output logic                         pick_valid,
	input  logic                         pick_ready,
	output logic [CHOSEN_BITS-1:0]       chosen_class,
	output logic                         word_end
);

	localparam int IDX_W = $clog2(MAX_CLASSES);
	localparam int SHARE_N = (MAX_CLASSES < SHARE_REGS) ? MAX_CLASSES : SHARE_REGS;
	localparam int BASE_W = (DEFICIT_BITS > SHARE_FRAC_BITS + 1) ? DEFICIT_BITS
		: SHARE_FRAC_BITS + 1;
	localparam int EXT_W = BASE_W + 2;
	localparam logic signed [EXT_W-1:0] DEF_MAX_X =
		{{(EXT_W-DEFICIT_BITS+1){1'b0}}, {(DEFICIT_BITS-1){1'b1}}};
	localparam logic signed [EXT_W-1:0] DEF_MIN_X =
		{{(EXT_W-DEFICIT_BITS+1){1'b1}}, {(DEFICIT_BITS-1){1'b0}}};
	localparam logic signed [EXT_W-1:0] UNIT_X = EXT_W'(1) << SHARE_FRAC_BITS;

	function automatic deficit_t sat(input logic signed [EXT_W-1:0] v);
		deficit_t r;
		if (v > DEF_MAX_X) begin
			r = DEF_MAX_X[DEFICIT_BITS-1:0];
		end else if (v < DEF_MIN_X) begin
			r = DEF_MIN_X[DEFICIT_BITS-1:0];
		end else begin
			r = v[DEFICIT_BITS-1:0];
		end
		return r;
	endfunction

	logic [CLASS_COUNT_BITS-1:0]  class_count_q;
	logic [WORD_LENGTH_BITS-1:0]  word_length_q;
	share_t                       share_q [SHARE_N];
	deficit_t [MAX_CLASSES-1:0]   deficit_q;
	logic [WORD_LENGTH_BITS-1:0]  position_q;

	deficit_t [MAX_CLASSES-1:0]   added;
	deficit_t [MAX_CLASSES-1:0]   taken;
	logic [MAX_CLASSES-1:0]       active;
	logic [IDX_W-1:0]             best;
	logic [WORD_LENGTH_BITS-1:0]  position_eff;
	logic                         last;
	logic                         accept;
	logic [CHOSEN_BITS+IDX_W-1:0] best_ext;

	for (genvar c = 0; c < MAX_CLASSES; c++) begin : g_class
		share_t   share_c;
		deficit_t start_c;
		if (c < SHARE_N) begin : g_share
			assign share_c = share_q[c];
		end else begin : g_noshare
			assign share_c = '0;
		end
		assign active[c] = (c == 0) || (int'(class_count_q) > c);
		assign start_c = restart ? '0 : deficit_q[c];
		assign added[c] = active[c]
			? sat(EXT_W'(start_c) + $signed({{(EXT_W-SHARE_BITS){1'b0}}, share_c}))
			: start_c;
		assign taken[c] = (best == IDX_W'(c)) ? sat(EXT_W'(added[c]) - UNIT_X) : added[c];
	end

	ldss_argmax #(
		.N(MAX_CLASSES),
		.IDX_W(IDX_W)
	) u_argmax (
		.vals(added),
		.active(active),
		.best(best)
	);

	assign position_eff = restart ? '0 : position_q;
	assign last = (position_eff == (word_length_q - WORD_LENGTH_BITS'(1)));
	assign tick_ready = !pick_valid || pick_ready;
	assign accept = tick_valid && tick_ready;
	assign best_ext = {{CHOSEN_BITS{1'b0}}, best};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= CLASS_COUNT_RESET;
			word_length_q <= WORD_LENGTH_RESET;
			for (int k = 0; k < SHARE_N; k++) begin
				share_q[k] <= SHARE_RESET[k];
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLASS_COUNT: begin
					class_count_q <= cfg_data[CLASS_COUNT_BITS-1:0];
				end
				REG_WORD_LENGTH: begin
					word_length_q <= cfg_data[WORD_LENGTH_BITS-1:0];
				end
				default: begin
					for (int k = 0; k < SHARE_N; k++) begin
						if (cfg_index == CFG_INDEX_BITS'(int'(REG_SHARE_FIRST) + k)) begin
							share_q[k] <= cfg_data[SHARE_BITS-1:0];
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deficit_q <= '0;
			position_q <= '0;
			pick_valid <= 1'b0;
		end else begin
			if (accept) begin
				pick_valid <= 1'b1;
				if (last) begin
					deficit_q <= '0;
					position_q <= '0;
				end else begin
					deficit_q <= taken;
					position_q <= position_eff + WORD_LENGTH_BITS'(1);
				end
			end else if (pick_ready) begin
				pick_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chosen_class <= best_ext[CHOSEN_BITS-1:0];
			word_end <= last;
		end
	end

endmodule

>>> test/largest_deficit_symbol_scheduler_tb.sv
`timescale 1ns / 1ps

module largest_deficit_symbol_scheduler_tb;
	import ldss_pkg::*;

	localparam int NUM_CLASSES = 4;
	localparam int FRAC_BITS = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BEYOND_FIRST =
		CFG_INDEX_BITS'(int'(REG_SHARE_FIRST) + SHARE_REGS);
	localparam logic [CFG_INDEX_BITS-1:0] REG_BEYOND_LAST =
		CFG_INDEX_BITS'(int'(REG_SHARE_FIRST) + SHARE_REGS + 1);

	class pick_scoreboard;
		typedef struct packed {
			logic [CHOSEN_BITS-1:0] chosen;
			logic word_end;
		} pick_t;

		logic [CLASS_COUNT_BITS-1:0] class_count;
		logic [WORD_LENGTH_BITS-1:0] word_length;
		share_t share [SHARE_REGS];
		longint deficit [NUM_CLASSES];
		logic [WORD_LENGTH_BITS-1:0] position;
		pick_t expected_picks [$];
		int errors;
		int picks_seen;

		function new();
			class_count = CLASS_COUNT_RESET;
			word_length = WORD_LENGTH_RESET;
			share = SHARE_RESET;
			errors = 0;
			picks_seen = 0;
			clear_word();
		endfunction

		function void clear_word();
			foreach (deficit[c]) deficit[c] = 0;
			position = '0;
		endfunction

		function longint saturate(longint v);
			longint hi;
			hi = (longint'(1) <<< (DEFICIT_BITS - 1)) - 1;
			if (v > hi) return hi;
			if (v < -hi - 1) return -hi - 1;
			return v;
		endfunction

		function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
				logic [CFG_DATA_BITS-1:0] data);
			if (idx == REG_CLASS_COUNT) class_count = data[CLASS_COUNT_BITS-1:0];
			else if (idx == REG_WORD_LENGTH) word_length = data[WORD_LENGTH_BITS-1:0];
			else if (idx >= REG_SHARE_FIRST && idx < REG_BEYOND_FIRST)
				share[idx - REG_SHARE_FIRST] = data[SHARE_BITS-1:0];
		endfunction

		function void note_tick(logic restart_bit);
			int active;
			int best;
			pick_t pick;
			if (restart_bit) clear_word();
			active = int'(class_count);
			if (active < 1) active = 1;
			if (active > NUM_CLASSES) active = NUM_CLASSES;
			for (int c = 0; c < active; c++) begin
				deficit[c] = saturate(deficit[c] + longint'(share[c]));
			end
			best = 0;
			for (int c = 1; c < active; c++) begin
				if (deficit[c] > deficit[best]) best = c;
			end
			deficit[best] = saturate(deficit[best] - (longint'(1) <<< FRAC_BITS));
			pick.chosen = best[CHOSEN_BITS-1:0];
			pick.word_end = (position == word_length - 32'd1);
			if (pick.word_end) clear_word();
			else position = position + 32'd1;
			expected_picks.push_back(pick);
		endfunction

		function int pending();
			return expected_picks.size();
		endfunction

		task report(string msg);
			$display("[%0t] mismatch on pick %0d: %s", $realtime, picks_seen, msg);
			errors++;
		endtask

		task check_pick(logic [CHOSEN_BITS-1:0] chosen, logic end_flag);
			pick_t want;
			if (expected_picks.size() == 0) begin
				report("pick transaction with nothing expected");
			end else begin
				want = expected_picks.pop_front();
				if (chosen !== want.chosen)
					report($sformatf("chosen_class %0d, expected %0d", chosen, want.chosen));
				if (end_flag !== want.word_end)
					report($sformatf("word_end %0b, expected %0b", end_flag, want.word_end));
			end
			picks_seen++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic tick_valid;
	logic tick_ready;
	logic restart;
	logic pick_valid;
	logic pick_ready;
	logic [CHOSEN_BITS-1:0] chosen_class;
	logic word_end;

	pick_scoreboard board;
	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold;
	int cycles;

	largest_deficit_symbol_scheduler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.tick_valid(tick_valid),
		.tick_ready(tick_ready),
		.restart(restart),
		.pick_valid(pick_valid),
		.pick_ready(pick_ready),
		.chosen_class(chosen_class),
		.word_end(word_end)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_valid && tick_ready) board.note_tick(restart);
			if (pick_valid && pick_ready) board.check_pick(chosen_class, word_end);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		pick_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				pick_ready = 1'b0;
				rx_hold--;
			end else begin
				pick_ready = ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_one(input logic rst);
		tick_valid = 1'b1;
		restart = rst;
		do @(posedge clk); while (!tick_ready);
		@(negedge clk);
	endtask

	task automatic run_segment(input int count, input int restart_pct);
		for (int i = 0; i < count; i++) begin
			while ($urandom_range(99) < tx_idle_pct) begin
				tick_valid = 1'b0;
				@(negedge clk);
			end
			send_one($urandom_range(99) < restart_pct);
		end
		tick_valid = 1'b0;
	endtask

	task automatic settle();
		tick_valid = 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		board.set_register(idx, data);
	endtask

	task automatic random_config();
		logic [CFG_DATA_BITS-1:0] data;
		if ($urandom_range(3) != 0) begin
			data = $urandom;
			if ($urandom_range(9) < 8)
				data[CLASS_COUNT_BITS-1:0] =
					CLASS_COUNT_BITS'($urandom_range(1, NUM_CLASSES));
			write_reg(REG_CLASS_COUNT, data);
		end
		if ($urandom_range(3) != 0) begin
			case ($urandom_range(3))
				0: data = $urandom_range(1, 8);
				1: data = $urandom_range(9, 200);
				2: data = $urandom_range(1, 3);
				default: data = $urandom;
			endcase
			write_reg(REG_WORD_LENGTH, data);
		end
		for (int k = 0; k < SHARE_REGS; k++) begin
			if ($urandom_range(2) != 0) begin
				data = $urandom;
				case ($urandom_range(5))
					0: data[SHARE_BITS-1:0] = '0;
					1: data[SHARE_BITS-1:0] = '1;
					2: data[SHARE_BITS-1:0] = SHARE_BITS'($urandom_range(0, 24576));
					default: ;
				endcase
				write_reg(CFG_INDEX_BITS'(int'(REG_SHARE_FIRST) + k), data);
			end
		end
		if ($urandom_range(7) == 0)
			write_reg($urandom_range(1) ? REG_BEYOND_LAST : REG_BEYOND_FIRST, $urandom);
	endtask

	initial begin
		int done;
		int n;
		board = new();
		cycles = 0;
		rx_hold = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tick_valid = 1'b0;
		restart = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_one(1'b0);
		send_one(1'b0);
		send_one(1'b1);
		settle();
		write_reg(REG_CLASS_COUNT, 32'd0);
		send_one(1'b0);
		send_one(1'b1);
		settle();
		write_reg(REG_CLASS_COUNT, 32'hFFFF_FFFF);
		write_reg(REG_WORD_LENGTH, 32'd0);
		write_reg(REG_SHARE_FIRST, 32'd0);
		write_reg(CFG_INDEX_BITS'(int'(REG_SHARE_FIRST) + 1), 32'h0000_FFFF);
		write_reg(CFG_INDEX_BITS'(int'(REG_SHARE_FIRST) + 2), 32'hFFFF_0000);
		write_reg(CFG_INDEX_BITS'(int'(REG_SHARE_FIRST) + 3), 32'hFFFF_FFFF);
		repeat (4) send_one(1'b0);
		settle();
		write_reg(REG_BEYOND_FIRST, 32'hFFFF_FFFF);
		write_reg(REG_BEYOND_LAST, 32'hFFFF_FFFF);
		send_one(1'b0);
		settle();
		write_reg(REG_WORD_LENGTH, 32'hFFFF_FFFF);
		send_one(1'b0);
		send_one(1'b1);
		settle();
		write_reg(REG_WORD_LENGTH, 32'd200);
		repeat (6) send_one(1'b0);
		settle();
		// The position is now past the new word length, so the word only ends after a restart.
		write_reg(REG_WORD_LENGTH, 32'd2);
		repeat (3) send_one(1'b0);
		send_one(1'b1);
		send_one(1'b0);
		send_one(1'b0);
		settle();

		for (int regime = 0; regime < 3; regime++) begin
			tx_idle_pct = (regime == 0) ? 33 : (regime == 1) ? 46 : 0;
			rx_idle_pct = (regime == 0) ? 46 : (regime == 1) ? 33 : 0;
			done = 0;
			if (regime == 0) begin
				write_reg(REG_CLASS_COUNT, NUM_CLASSES);
				write_reg(REG_WORD_LENGTH, 32'd0);
				for (int k = 0; k < SHARE_REGS; k++)
					write_reg(CFG_INDEX_BITS'(int'(REG_SHARE_FIRST) + k), 32'hFFFF);
				run_segment(200, 0);
				done += 200;
				settle();
			end
			if (regime == 2) begin
				rx_hold = 150;
				run_segment(60, 2);
				done += 60;
				settle();
			end
			while (done < 450) begin
				random_config();
				n = $urandom_range(20, 100);
				run_segment(n, $urandom_range(0, 8));
				done += n;
				settle();
			end
		end

		settle();
		repeat (10) @(negedge clk);
		if (board.errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule
